FILE: sv/aligned_bitmap_run_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the aligned bitmap run allocator
// Clocked assertions that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define ALIGNED_BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define ABRA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ABRA_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ABRA_ASSERT(label, clk, rst_n, prop, msg)
`define ABRA_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: sv/abra_pkg.sv
// ----------------------------------------------------------------------------
// abra_pkg
// Shared types, status codes and defaults of the bitmap run allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package abra_pkg;
	localparam int MAP_UNITS_DEF = 1024;
	localparam int WORD_BITS_DEF = 32;

	localparam logic       MODE_ALLOC   = 1'b0;
	localparam logic       MODE_FREE    = 1'b1;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [1:0] ST_BAD_REQ   = 2'd2;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [10:0] run_length;
		logic [9:0]  alignment;
		logic [9:0]  free_offset;
	} req_t;

	typedef struct packed {
		logic [9:0]  run_offset;
		logic [1:0]  status;
		logic [10:0] units_used;
	} rsp_t;
endpackage
`default_nettype wire

FILE: sv/abra_mem.sv
// ----------------------------------------------------------------------------
// abra_mem
// Bitmap word memory, one read and one write port, registered read data.
// Per-word valid flags make unwritten words read as clear.
// ----------------------------------------------------------------------------
`default_nettype none
module abra_mem #(
	parameter int MAP_UNITS = abra_pkg::MAP_UNITS_DEF,
	parameter int WORD_BITS = abra_pkg::WORD_BITS_DEF,
	localparam int WORD_COUNT = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS,
	localparam int WIW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [WIW-1:0]       rd_addr,
	output logic      [WORD_BITS-1:0] rd_data,
	input  wire logic                 wr_en,
	input  wire logic [WIW-1:0]       wr_addr,
	input  wire logic [WORD_BITS-1:0] wr_data
);
	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] vld_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic                 rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;
endmodule
`default_nettype wire

FILE: sv/abra_engine.sv
// ----------------------------------------------------------------------------
// abra_engine
// Request sequencer: walks the bitmap unit by unit through a one-word cache
// that fronts the memory, writes modified words straight back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aligned_bitmap_run_allocator_defines.svh"
module abra_engine #(
	parameter int MAP_UNITS = abra_pkg::MAP_UNITS_DEF,
	parameter int WORD_BITS = abra_pkg::WORD_BITS_DEF,
	localparam int WORD_COUNT = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS,
	localparam int WIW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
	localparam int BIW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1,
	localparam int SW = ($clog2(MAP_UNITS) + 3 > 12) ? $clog2(MAP_UNITS) + 3 : 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire abra_pkg::req_t       req,
	input  wire logic [SW-1:0]        size,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output abra_pkg::rsp_t            res,
	output logic                      rd_en,
	output logic      [WIW-1:0]       rd_addr,
	input  wire logic [WORD_BITS-1:0] rd_data,
	output logic                      wr_en,
	output logic      [WIW-1:0]       wr_addr,
	output logic      [WORD_BITS-1:0] wr_data
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_ADV   = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_SET   = 4'd4;
	localparam logic [3:0] S_FCHK  = 4'd5;
	localparam logic [3:0] S_FCLR  = 4'd6;
	localparam logic [3:0] S_MISS  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]           state_q, ret_q;
	logic [SW-1:0]        off_q, nxt_q, cnt_q, i_q, len_q, mask_q, ss_q, used_q;
	logic [WORD_BITS-1:0] cache_q;
	logic [WIW-1:0]       cidx_q, midx_q;
	logic                 cv_q;
	logic [9:0]           roff_q;
	logic [1:0]           rst_q;

	logic [SW-1:0]        u;
	logic [WIW-1:0]       u_w;
	logic [BIW-1:0]       u_b;
	logic                 hit, bitv, need_acc, miss;
	logic [9:0]           align1, mask10;
	logic [SW-1:0]        len_in, foff_in, ss_eff, off0;
	logic                 bad_a, bad_f;
	logic [SW-1:0]        n2, c2, o2;
	logic                 oos, wrapf;

	always_comb begin
		unique case (state_q)
			S_SCAN:  u = nxt_q;
			default: u = off_q + i_q;
		endcase
		u_w = WIW'(u / WORD_BITS);
		u_b = BIW'(u % WORD_BITS);
		hit = cv_q && (cidx_q == u_w);
		bitv = cache_q[u_b];
		unique case (state_q) inside
			S_SCAN:                         need_acc = nxt_q < size;
			S_CHK, S_SET, S_FCHK, S_FCLR:   need_acc = i_q != len_q;
			default:                        need_acc = 1'b0;
		endcase
		miss = need_acc && !hit;
		rd_en = miss;
		rd_addr = u_w;
		wr_en = need_acc && hit && (state_q == S_SET || state_q == S_FCLR);
		wr_addr = u_w;
		wr_data = cache_q;
		wr_data[u_b] = (state_q == S_SET);

		align1 = (req.alignment == 10'd0) ? 10'd1 : req.alignment;
		mask10 = align1 - 10'd1;
		len_in = SW'(req.run_length);
		foff_in = SW'(req.free_offset);
		bad_a = ((align1 & mask10) != 10'd0) || (SW'(align1) >= size) ||
			(len_in == '0) || (len_in > size);
		bad_f = (len_in == '0) || (foff_in + len_in > size) || (len_in > used_q);
		ss_eff = (ss_q >= size) ? '0 : ss_q;
		off0 = ss_eff & ~SW'(mask10);

		n2 = (nxt_q + mask_q) & ~mask_q;
		c2 = cnt_q + n2 - off_q;
		o2 = (n2 >= size) ? '0 : n2;
		oos = c2 + len_q > size;
		wrapf = o2 + len_q > size;
	end

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.run_offset = roff_q;
	assign res.status = rst_q;
	assign res.units_used = used_q[10:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			ss_q    <= '0;
			used_q  <= '0;
			cv_q    <= 1'b0;
		end else begin
			unique case (state_q) inside
				S_IDLE: begin
					if (in_valid) begin
						len_q <= len_in;
						i_q   <= '0;
						roff_q <= '0;
						if (req.mode == abra_pkg::MODE_ALLOC) begin
							mask_q <= SW'(mask10);
							off_q <= off0;
							nxt_q <= off0;
							cnt_q <= '0;
							if (bad_a) begin
								rst_q <= abra_pkg::ST_BAD_REQ;
								state_q <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							off_q <= foff_in;
							if (bad_f) begin
								rst_q <= abra_pkg::ST_BAD_REQ;
								state_q <= S_DONE;
							end else begin
								state_q <= S_FCHK;
							end
						end
					end
				end
				S_SCAN: begin
					if (miss) begin
						ret_q <= state_q;
						midx_q <= u_w;
						state_q <= S_MISS;
					end else if (need_acc && bitv) begin
						nxt_q <= nxt_q + 1'b1;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					cnt_q <= c2;
					off_q <= o2;
					i_q <= '0;
					if (oos) begin
						rst_q <= abra_pkg::ST_NO_SPACE;
						state_q <= S_DONE;
					end else if (wrapf) begin
						cnt_q <= c2 + size - o2;
						off_q <= '0;
						nxt_q <= '0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!need_acc) begin
						i_q <= '0;
						state_q <= S_SET;
					end else if (miss) begin
						ret_q <= state_q;
						midx_q <= u_w;
						state_q <= S_MISS;
					end else if (!bitv) begin
						i_q <= i_q + 1'b1;
					end else begin
						cnt_q <= cnt_q + i_q + 1'b1;
						if (off_q + i_q + 1'b1 >= size) begin
							off_q <= '0;
							nxt_q <= '0;
						end else begin
							off_q <= off_q + i_q + 1'b1;
							nxt_q <= off_q + i_q + 1'b1;
						end
						state_q <= S_SCAN;
					end
				end
				S_SET, S_FCLR: begin
					if (!need_acc) begin
						rst_q <= abra_pkg::ST_OK;
						if (state_q == S_SET) begin
							roff_q <= off_q[9:0];
							ss_q <= (off_q + len_q >= size) ? '0 : off_q + len_q;
							used_q <= used_q + len_q;
						end else begin
							used_q <= used_q - len_q;
						end
						state_q <= S_DONE;
					end else if (miss) begin
						ret_q <= state_q;
						midx_q <= u_w;
						state_q <= S_MISS;
					end else begin
						cache_q <= wr_data;
						i_q <= i_q + 1'b1;
					end
				end
				S_FCHK: begin
					if (!need_acc) begin
						i_q <= '0;
						state_q <= S_FCLR;
					end else if (miss) begin
						ret_q <= state_q;
						midx_q <= u_w;
						state_q <= S_MISS;
					end else if (!bitv) begin
						rst_q <= abra_pkg::ST_NOT_ALLOC;
						state_q <= S_DONE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_MISS: begin
					cache_q <= rd_data;
					cidx_q <= midx_q;
					cv_q <= 1'b1;
					state_q <= ret_q;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ABRA_ASSERT(a_miss_from_walk, clk, arst_n, (state_q == S_MISS) |-> ($past(state_q) != S_IDLE && $past(state_q) != S_MISS), "miss entered from idle or miss")
	`ABRA_ASSERT(a_write_states, clk, arst_n, wr_en |-> (state_q == S_SET || state_q == S_FCLR), "bitmap write outside set or clear")
	`ABRA_ASSERT(a_fill_valid, clk, arst_n, (state_q == S_MISS) |=> (cv_q && cidx_q == $past(midx_q)), "cache not filled after miss")
endmodule
`default_nettype wire

FILE: sv/aligned_bitmap_run_allocator.sv
// Sequence: an allocate scans for a clear unit from the rotating start, aligns the candidate,
// checks the run unit by unit and then sets it, moving on past any set unit; a free checks the
// run and then clears it; each bitmap word fetched into the one-word cache adds a miss state.
// Throughput: one request at a time; the engine takes the next request only after the result
// has left the engine. Reset (arst_n low): bitmap reads clear, rotating start 0, used count 0,
// map_size MAP_UNITS capped at 2047.
// ----------------------------------------------------------------------------
// aligned_bitmap_run_allocator
// Next-fit aligned run allocator over a bitmap of allocation units.
// ----------------------------------------------------------------------------
`default_nettype none
module aligned_bitmap_run_allocator #(
	parameter int MAP_UNITS = abra_pkg::MAP_UNITS_DEF,
	parameter int WORD_BITS = abra_pkg::WORD_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire abra_pkg::req_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output abra_pkg::rsp_t      out_data,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [10:0]    cfg_data
);
	localparam int WORD_COUNT = (MAP_UNITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int SW = ($clog2(MAP_UNITS) + 3 > 12) ? $clog2(MAP_UNITS) + 3 : 12;
	localparam logic [10:0] SIZE_RST = (MAP_UNITS > 2047) ? 11'd2047 : 11'(MAP_UNITS);

	logic [10:0]          map_size_q;
	logic [SW-1:0]        size;
	logic                 out_v_q;
	abra_pkg::rsp_t       out_q;
	logic                 res_valid, res_ready;
	abra_pkg::rsp_t       res;
	logic                 rd_en, wr_en;
	logic [WIW-1:0]       rd_addr, wr_addr;
	logic [WORD_BITS-1:0] rd_data, wr_data;

	// Register writes are always taken; hold the size in use.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_size_q <= SIZE_RST;
		end else if (cfg_valid) begin
			map_size_q <= cfg_data;
		end
	end

	// Saturate the programmed size at the map depth.
	assign size = (SW'(map_size_q) > SW'(MAP_UNITS)) ? SW'(MAP_UNITS) : SW'(map_size_q);

	// Output register: drop the finished result here so the engine can take
	// the next request while the consumer stalls.
	assign res_ready = !out_v_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end
	assign out_valid = out_v_q;
	assign out_data = out_q;

	abra_engine #(.MAP_UNITS(MAP_UNITS), .WORD_BITS(WORD_BITS)) u_engine (
		.clk, .arst_n,
		.in_valid, .in_ready, .req(in_data), .size,
		.res_valid, .res_ready, .res,
		.rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
	);

	abra_mem #(.MAP_UNITS(MAP_UNITS), .WORD_BITS(WORD_BITS)) u_mem (
		.clk, .arst_n,
		.rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
	);
endmodule
`default_nettype wire

FILE: test/aligned_bitmap_run_allocator_tb.sv
// ----------------------------------------------------------------------------
// aligned_bitmap_run_allocator_tb
// Drives allocate and free requests into the run allocator and checks every
// response against a directed expected value or a local next-fit bitmap model.
// A short directed table comes first, then random phases at several map sizes.
// Random stalls fall on both sides, and there is one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none
module aligned_bitmap_run_allocator_tb;
	localparam int UNITS      = 1024;
	localparam int IDLE_LIMIT = 40000;

	typedef struct {
		abra_pkg::req_t r;
		bit             typed;
		abra_pkg::rsp_t e;
	} row_t;

	typedef struct {
		int off;
		int len;
	} run_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	abra_pkg::req_t in_data;
	logic           out_valid;
	logic           out_ready = 1'b0;
	abra_pkg::rsp_t out_data;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [10:0]    cfg_data;

	// local copy of the allocator state
	bit             unit_map [0:UNITS-1];
	int             rot_start;
	int             used_units;
	int             map_cap;

	abra_pkg::rsp_t pending_rsp [$];
	run_t           live_runs [$];
	row_t           dir_rows [$];
	int             err_count = 0;
	int             rsp_count = 0;
	int             idle_cycles = 0;

	aligned_bitmap_run_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic bit unit_set(int u);
		return (u < UNITS) ? unit_map[u] : 1'b0;
	endfunction

	// Next-fit allocate with wrap, or free; returns the response and updates the local state.
	function automatic abra_pkg::rsp_t alloc_or_free(abra_pkg::req_t r);
		abra_pkg::rsp_t res;
		int   size, len, align, mask, offset, count, nxt, i, k;
		size = (map_cap > UNITS) ? UNITS : map_cap;
		len  = r.run_length;
		res  = '0;
		if (r.mode == abra_pkg::MODE_ALLOC) begin
			align = (r.alignment == 0) ? 1 : r.alignment;
			mask  = align - 1;
			if ((align & mask) != 0 || align >= size || len == 0 || len > size) begin
				res.status = abra_pkg::ST_BAD_REQ;
			end else begin
				offset = ((rot_start >= size) ? 0 : rot_start) & ~mask;
				count  = 0;
				forever begin
					nxt = offset;
					while (nxt < size && unit_set(nxt)) nxt++;
					nxt = (nxt + mask) & ~mask;
					count += nxt - offset;
					offset = nxt;
					if (offset >= size) offset = 0;
					if (count + len > size) begin
						res.status = abra_pkg::ST_NO_SPACE;
						break;
					end
					if (offset + len > size) begin
						// skip the tail and wrap
						count += size - offset;
						offset = 0;
						continue;
					end
					i = 0;
					while (i < len && !unit_set(offset + i)) i++;
					if (i == len) begin
						for (k = 0; k < len; k++) unit_map[offset + k] = 1'b1;
						rot_start = offset + len;
						if (rot_start >= size) rot_start = 0;
						used_units += len;
						res.status = abra_pkg::ST_OK;
						res.run_offset = offset;
						live_runs.push_back('{offset, len});
						break;
					end
					count += i + 1;
					offset += i + 1;
					if (offset >= size) offset = 0;
				end
			end
		end else begin
			offset = r.free_offset;
			if (len == 0 || offset + len > size || len > used_units) begin
				res.status = abra_pkg::ST_BAD_REQ;
			end else begin
				res.status = abra_pkg::ST_OK;
				for (k = 0; k < len; k++)
					if (!unit_set(offset + k)) res.status = abra_pkg::ST_NOT_ALLOC;
				if (res.status == abra_pkg::ST_OK) begin
					for (k = 0; k < len; k++) unit_map[offset + k] = 1'b0;
					used_units -= len;
					for (k = 0; k < live_runs.size(); k++)
						if (live_runs[k].off == offset) begin
							live_runs.delete(k);
							break;
						end
				end
			end
		end
		res.units_used = used_units;
		return res;
	endfunction

	// Offer one request; hold valid and payload until accepted.
	task automatic send_req(abra_pkg::req_t r, bit typed, abra_pkg::rsp_t want, bit quiet);
		abra_pkg::rsp_t pred;
		if (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
		pred = alloc_or_free(r);
		pending_rsp.push_back(typed ? want : pred);
	endtask

	task automatic write_map_size(logic [10:0] v);
		in_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		map_cap = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic abra_pkg::req_t random_req(int size);
		abra_pkg::req_t r;
		int   p, q, span, pick;
		r    = '0;
		p    = $urandom_range(99);
		q    = $urandom_range(99);
		span = (size >= 4) ? size / 4 : 1;
		if (p < 55) begin
			r.mode        = abra_pkg::MODE_ALLOC;
			r.free_offset = $urandom;
			if (q < 70) r.alignment = 10'd1 << $urandom_range(0, 3);
			else if (q < 85) r.alignment = '0;
			else r.alignment = $urandom;
			if ($urandom_range(99) < 88) r.run_length = $urandom_range(1, span);
			else r.run_length = $urandom;
		end else begin
			r.mode      = abra_pkg::MODE_FREE;
			r.alignment = $urandom;
			if (live_runs.size() > 0 && q < 85) begin
				pick          = $urandom_range(0, live_runs.size() - 1);
				r.free_offset = live_runs[pick].off;
				r.run_length  = live_runs[pick].len;
			end else begin
				r.free_offset = $urandom;
				r.run_length  = (q < 95) ? $urandom_range(0, 16) : $urandom;
			end
		end
		return r;
	endfunction

	task automatic add_row(logic m, int len, int al, int fo, bit typed,
			int roff, logic [1:0] st, int used);
		row_t row;
		row.r     = '{mode: m, run_length: len, alignment: al, free_offset: fo};
		row.typed = typed;
		row.e     = '{run_offset: roff, status: st, units_used: used};
		dir_rows.push_back(row);
	endtask

	// response checker
	always @(posedge clk) begin
		abra_pkg::rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected response", 1, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (out_data.run_offset !== want.run_offset)
					report("run_offset", out_data.run_offset, want.run_offset);
				if (out_data.status !== want.status)
					report("status", out_data.status, want.status);
				if (out_data.units_used !== want.units_used)
					report("units_used", out_data.units_used, want.units_used);
			end
			rsp_count++;
		end
	end

	// receiver stalls, including one long hold-off
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (!hold_done && rsp_count >= 300) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rsp_count >= 800 && rsp_count < 1100) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 6);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [10:0] sizes [14] = '{11'd1024, 11'd8, 11'd16, 11'd2047, 11'd64, 11'd0,
			11'd32, 11'd128, 11'd24, 11'd1024, 11'd40, 11'd8, 11'd256, 11'd1000};
		int   n;
		int   size;
		abra_pkg::rsp_t none;
		none        = '0;
		rot_start   = 0;
		used_units  = 0;
		map_cap     = UNITS;
		foreach (unit_map[i]) unit_map[i] = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows from reset, full map
		add_row(abra_pkg::MODE_ALLOC, 1, 0, 0, 1, 0, abra_pkg::ST_OK, 1);
		add_row(abra_pkg::MODE_ALLOC, 0, 1, 0, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		add_row(abra_pkg::MODE_ALLOC, 1025, 1, 0, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		add_row(abra_pkg::MODE_ALLOC, 2047, 1023, 1023, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		add_row(abra_pkg::MODE_ALLOC, 4, 3, 0, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		add_row(abra_pkg::MODE_ALLOC, 1, 512, 0, 1, 512, abra_pkg::ST_OK, 2);
		add_row(abra_pkg::MODE_FREE, 1, 0, 0, 1, 0, abra_pkg::ST_OK, 1);
		// freeing a clear unit
		add_row(abra_pkg::MODE_FREE, 1, 0, 0, 1, 0, abra_pkg::ST_NOT_ALLOC, 1);
		add_row(abra_pkg::MODE_FREE, 0, 0, 5, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		add_row(abra_pkg::MODE_FREE, 2, 0, 1023, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		add_row(abra_pkg::MODE_FREE, 1024, 0, 0, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		add_row(abra_pkg::MODE_FREE, 2047, 1023, 1023, 1, 0, abra_pkg::ST_BAD_REQ, 1);
		// run of the whole map cannot fit any more, then wrap and alignment cases
		add_row(abra_pkg::MODE_ALLOC, 1024, 1, 0, 0, 0, abra_pkg::ST_OK, 0);
		add_row(abra_pkg::MODE_ALLOC, 511, 0, 0, 0, 0, abra_pkg::ST_OK, 0);
		add_row(abra_pkg::MODE_ALLOC, 300, 256, 0, 0, 0, abra_pkg::ST_OK, 0);
		add_row(abra_pkg::MODE_ALLOC, 8, 8, 0, 0, 0, abra_pkg::ST_OK, 0);
		add_row(abra_pkg::MODE_FREE, 1, 0, 512, 0, 0, abra_pkg::ST_OK, 0);
		add_row(abra_pkg::MODE_ALLOC, 600, 1, 0, 0, 0, abra_pkg::ST_OK, 0);
		add_row(abra_pkg::MODE_ALLOC, 1, 1, 0, 0, 0, abra_pkg::ST_OK, 0);
		foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e, 0);

		// random phases; each size change waits for the block to drain
		n = 0;
		foreach (sizes[p]) begin
			write_map_size(sizes[p]);
			size = (map_cap > UNITS) ? UNITS : map_cap;
			repeat (125) begin
				send_req(random_req(size), 0, none, (n >= 600 && n < 900));
				n++;
			end
		end
		in_valid <= 1'b0;
		wait (pending_rsp.size() == 0);
		repeat (50) @(posedge clk);
		if (err_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
